@@ rtl/page_frame_refcount_allocator_macros.svh @@
// Assertion helpers for the checker file.
`ifndef PAGE_FRAME_REFCOUNT_ALLOCATOR_MACROS_SVH
`define PAGE_FRAME_REFCOUNT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFRA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PFRA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/pfra_pkg.sv @@
`default_nettype none

package pfra_pkg;

  localparam int MAX_FRAMES = 4096;
  localparam int SLOT_W     = $clog2(MAX_FRAMES);
  localparam int ROW_BITS   = 64;
  localparam int BIT_W      = $clog2(ROW_BITS);
  localparam int ROWS       = MAX_FRAMES / ROW_BITS;
  localparam int ROW_W      = $clog2(ROWS);
  localparam int POOL_W     = $clog2(MAX_FRAMES) + 1;
  localparam int FRAME_W    = 20;
  localparam int COUNT_W    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [COUNT_W-1:0] COUNT_MAX     = 7'h7F;
  localparam logic [FRAME_W:0]   FRAME_SPACE   = 21'h100000;
  localparam logic [POOL_W-1:0]  POOL_MAX      = POOL_W'(MAX_FRAMES);
  localparam logic [POOL_W-1:0]  FRAME_CNT_RST = 13'd4096;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_FRAME  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 2'd1;

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_ADD_REF = 2'd2,
    KIND_QUERY   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OOM       = 2'd1,
    ST_IGNORED   = 2'd2,
    ST_SATURATED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_PREP = 3'd1,
    S_READ = 3'd2,
    S_CALC = 3'd3,
    S_DONE = 3'd4
  } state_e;

endpackage

`default_nettype wire

@@ rtl/page_frame_refcount_allocator.sv @@
// Page frame reference-count allocator.
// The input channel (in_valid_i/in_ready_o) carries one request item: kind_i and
// frame_i. The output channel (out_valid_o/out_ready_i) returns exactly one result
// item per request: status_o, granted_frame_o and ref_count_o.
// Counts live in a 4096-entry memory; a 64 x 64 free bitmap and a 64-bit summary
// of rows holding a free frame let an allocate find the lowest free frame with two
// priority encoders and one bitmap read.
// Each item passes through the PREP, READ, CALC and DONE states, a read-modify-write
// pass through the memories, and its result then moves to the output register; a new
// item is accepted only back in IDLE, so no item is taken before the last is done.
// The block accepts a new item while an earlier result still waits in the output
// register. If the receiver stalls, the finished item waits in its last step
// until the output register frees, and no new item is accepted meanwhile.
// Reset marks every row free in the summary and clears the per-row valid bits, so
// every frame reads as free at once; there is no clearing pass. Configuration
// writes through cfg_we_i are registered, the clipped pool size after them, and do
// not disturb the stored counts.
`default_nettype none

module page_frame_refcount_allocator import pfra_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [1:0]            kind_i,
  input  wire logic [FRAME_W-1:0]    frame_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [1:0]                 status_o,
  output logic [FRAME_W-1:0]         granted_frame_o,
  output logic [COUNT_W-1:0]         ref_count_o
);

  function automatic logic [BIT_W-1:0] lowest_set(input logic [ROW_BITS-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = ROW_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [ROW_W-1:0] lowest_row(input logic [ROWS-1:0] v);
    logic [ROW_W-1:0] idx;
    idx = '0;
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = ROW_W'(i);
      end
    end
    return idx;
  endfunction

  state_e state_q, state_d;

  logic [FRAME_W-1:0] base_q;
  logic [POOL_W-1:0]  frame_count_q;
  logic [POOL_W-1:0]  pool_n_q, pool_n_d;

  kind_e              kind_q;
  logic [FRAME_W-1:0] frame_q;
  logic [SLOT_W-1:0]  slot_q;
  logic               hit_q;
  logic               any_q;

  logic [ROWS-1:0]    summary_q;
  logic [ROWS-1:0]    row_valid_q;

  logic [COUNT_W-1:0]  count_mem [MAX_FRAMES];
  logic [ROW_BITS-1:0] row_mem [ROWS];
  logic [COUNT_W-1:0]  cnt_rd_q;
  logic [ROW_BITS-1:0] row_rd_q;
  logic                row_ok_q;

  logic [1:0]          res_status_q, res_status_d;
  logic [FRAME_W-1:0]  res_granted_q, res_granted_d;
  logic [COUNT_W-1:0]  res_count_q, res_count_d;
  logic                wr_en_q, wr_en_d;
  logic [ROW_BITS-1:0] wr_row_q, wr_row_d;
  logic [SLOT_W-1:0]   wr_slot_q, wr_slot_d;

  logic               out_valid_q;
  logic [1:0]         status_q;
  logic [FRAME_W-1:0] granted_q;
  logic [COUNT_W-1:0] ref_count_q;

  logic in_fire;
  logic done_fire;
  logic out_free;

  logic [FRAME_W:0]   room;
  logic [FRAME_W-1:0] offset;
  logic               in_pool;

  logic [ROW_BITS-1:0] row_eff;
  logic [BIT_W-1:0]    free_bit;
  logic [SLOT_W-1:0]   cand;
  logic                cur_free;
  logic [COUNT_W-1:0]  cur;

  assign out_free = !out_valid_q || out_ready_i;
  assign in_fire  = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_PREP;
        end
      end
      S_PREP: state_d = S_READ;
      S_READ: state_d = S_CALC;
      S_CALC: state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    done_fire  = 1'b0;
    case (state_q)
      S_IDLE:  in_ready_o = 1'b1;
      S_DONE:  done_fire  = out_free;
      default: begin
        in_ready_o = 1'b0;
        done_fire  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Pool size is the configured count clipped to the store and to the frame space.
  always_comb begin
    room     = FRAME_SPACE - {1'b0, base_q};
    pool_n_d = frame_count_q;
    if (pool_n_d > POOL_MAX) begin
      pool_n_d = POOL_MAX;
    end
    if ({{(FRAME_W + 1 - POOL_W){1'b0}}, pool_n_d} > room) begin
      pool_n_d = room[POOL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q        <= '0;
      frame_count_q <= FRAME_CNT_RST;
      pool_n_q      <= POOL_MAX;
    end else begin
      pool_n_q <= pool_n_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_BASE_FRAME:  base_q        <= cfg_data_i[FRAME_W-1:0];
          CFG_FRAME_COUNT: frame_count_q <= cfg_data_i[POOL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign offset  = frame_q - base_q;
  assign in_pool = (frame_q >= base_q) &&
                   ({1'b0, offset} < {{(FRAME_W + 1 - POOL_W){1'b0}}, pool_n_q});

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q  <= kind_e'(kind_i);
      frame_q <= frame_i;
    end
    if (state_q == S_PREP) begin
      any_q <= |summary_q;
      hit_q <= in_pool;
      if (kind_q == KIND_ALLOC) begin
        slot_q <= {lowest_row(summary_q), {BIT_W{1'b0}}};
      end else begin
        slot_q <= offset[SLOT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_fire && wr_en_q) begin
      count_mem[wr_slot_q] <= res_count_q;
      row_mem[wr_slot_q[SLOT_W-1:BIT_W]] <= wr_row_q;
    end
    cnt_rd_q <= count_mem[slot_q];
    row_rd_q <= row_mem[slot_q[SLOT_W-1:BIT_W]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      summary_q   <= '1;
      row_valid_q <= '0;
      row_ok_q    <= 1'b0;
    end else begin
      row_ok_q <= row_valid_q[slot_q[SLOT_W-1:BIT_W]];
      if (done_fire && wr_en_q) begin
        summary_q[wr_slot_q[SLOT_W-1:BIT_W]]   <= |wr_row_q;
        row_valid_q[wr_slot_q[SLOT_W-1:BIT_W]] <= 1'b1;
      end
    end
  end

  // A set bitmap bit means the count is zero; the count memory is then not consulted.
  assign row_eff  = row_ok_q ? row_rd_q : '1;
  assign free_bit = lowest_set(row_eff);
  assign cand     = {slot_q[SLOT_W-1:BIT_W], free_bit};
  assign cur_free = row_eff[slot_q[BIT_W-1:0]];
  assign cur      = cur_free ? '0 : cnt_rd_q;

  always_comb begin
    res_status_d  = ST_OK;
    res_granted_d = '0;
    res_count_d   = '0;
    wr_en_d       = 1'b0;
    wr_row_d      = row_eff;
    wr_slot_d     = slot_q;
    case (kind_q)
      KIND_ALLOC: begin
        if (any_q && ({1'b0, cand} < pool_n_q)) begin
          res_granted_d       = base_q + {{(FRAME_W - SLOT_W){1'b0}}, cand};
          res_count_d         = COUNT_W'(1);
          wr_en_d             = 1'b1;
          wr_slot_d           = cand;
          wr_row_d[free_bit]  = 1'b0;
        end else begin
          res_status_d = ST_OOM;
        end
      end
      KIND_RELEASE: begin
        if (!hit_q || cur_free) begin
          res_status_d = ST_IGNORED;
        end else begin
          res_count_d = cur - COUNT_W'(1);
          wr_en_d     = 1'b1;
          wr_row_d[slot_q[BIT_W-1:0]] = (cur == COUNT_W'(1));
        end
      end
      KIND_ADD_REF: begin
        if (!hit_q) begin
          res_status_d = ST_IGNORED;
        end else if (cur == COUNT_MAX) begin
          res_status_d = ST_SATURATED;
          res_count_d  = COUNT_MAX;
        end else begin
          res_count_d = cur + COUNT_W'(1);
          wr_en_d     = 1'b1;
          wr_row_d[slot_q[BIT_W-1:0]] = 1'b0;
        end
      end
      KIND_QUERY: begin
        if (!hit_q) begin
          res_status_d = ST_IGNORED;
        end else begin
          res_count_d = cur;
        end
      end
      default: res_status_d = ST_IGNORED;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_CALC) begin
      res_status_q  <= res_status_d;
      res_granted_q <= res_granted_d;
      res_count_q   <= res_count_d;
      wr_row_q      <= wr_row_d;
      wr_slot_q     <= wr_slot_d;
    end
    if (done_fire) begin
      status_q    <= res_status_q;
      granted_q   <= res_granted_q;
      ref_count_q <= res_count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_en_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_CALC) begin
        wr_en_q <= wr_en_d;
      end
      if (done_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign granted_frame_o = granted_q;
  assign ref_count_o     = ref_count_q;

endmodule

`default_nettype wire

@@ rtl/pfra_checker.sv @@
`default_nettype none
`include "page_frame_refcount_allocator_macros.svh"

module pfra_checker import pfra_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic [1:0]         status_o,
  input wire logic [FRAME_W-1:0] granted_frame_o,
  input wire logic [COUNT_W-1:0] ref_count_o
);

  `PFRA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o) && $stable(granted_frame_o) && $stable(ref_count_o), "Stalled result item changed.")
  `PFRA_ASSERT_NXT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "Item accepted while another is in flight.")
  `PFRA_ASSERT_IMP(a_oom_clean, clk_i, rst_ni, out_valid_o && (status_o == ST_OOM || status_o == ST_IGNORED), granted_frame_o == '0 && ref_count_o == '0, "Failed item carries data.")
  `PFRA_ASSERT_IMP(a_sat_count, clk_i, rst_ni, out_valid_o && status_o == ST_SATURATED, ref_count_o == COUNT_MAX && granted_frame_o == '0, "Saturated item has wrong count.")
  `PFRA_ASSERT_IMP(a_grant_count, clk_i, rst_ni, out_valid_o && status_o == ST_OK && granted_frame_o != '0, ref_count_o == 7'd1, "Granted frame count is not one.")

endmodule

bind page_frame_refcount_allocator pfra_checker u_pfra_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .status_o        (status_o),
  .granted_frame_o (granted_frame_o),
  .ref_count_o     (ref_count_o)
);

`default_nettype wire
